@@ hdl/opmm_pkg.sv @@
// ============================================================================
// Order-preserving multi-pattern matcher: shared package
// Types, codes and stream layout constants used by the matcher and checker.
// ============================================================================
package opmm_pkg;

  // Kind of an input beat, carried in tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEXT = 1'b1;

  // Stream widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 80;
  localparam int CFG_W      = 9;
  localparam int HERE_W     = 9;
  localparam int POS_W      = 32;
  localparam int TOTAL_W    = 32;

  // Input tdata layout
  localparam int IN_SLOT_LSB = 0;
  localparam int IN_EL_LSB   = 8;
  localparam int IN_VAL_LSB  = 11;

  // Output tdata layout
  localparam int OUT_FULL_BIT  = 0;
  localparam int OUT_POS_LSB   = 1;
  localparam int OUT_HERE_LSB  = 33;
  localparam int OUT_TOTAL_LSB = 42;
  localparam int OUT_PAD_LSB   = 74;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

@@ hdl/opmm_ram.sv @@
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module opmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/opmm_cell.sv @@
// ============================================================================
// Window cell
// Holds one window value, passes it to its lower neighbor on each text beat,
// and checks the order relations of its position against all later ones.
// ============================================================================
module opmm_cell import opmm_pkg::*; #(
  parameter int IDX        = 0,
  parameter int PAT_LEN    = 8,
  parameter int VALUE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 shift,
  input  logic [VALUE_BITS-1:0]                shift_in,
  input  logic [PAT_LEN-1:0][VALUE_BITS-1:0]   win,
  input  logic [PAT_LEN-1:0][VALUE_BITS-1:0]   pat,
  output logic [VALUE_BITS-1:0]                value,
  output logic                                 ok
);

  // Hold the window value; advance from the upper neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (shift) begin
      value <= shift_in;
    end
  end

  // Compare less/greater relations against every later position
  always_comb begin
    ok = 1'b1;
    for (int j = IDX + 1; j < PAT_LEN; j++) begin
      if (((pat[IDX] < pat[j]) != (win[IDX] < win[j])) ||
          ((pat[IDX] > pat[j]) != (win[IDX] > win[j]))) begin
        ok = 1'b0;
      end
    end
  end

endmodule

@@ hdl/order_preserving_multi_matcher_top.sv @@
// ============================================================================
// Order-preserving multi-pattern matcher, top level
// Loads equal-length patterns into a row RAM and, for each text value, counts
// the patterns whose pairwise order matches the window of recent values.
// ============================================================================
//  channel  | dir | beat contents
//  s_axis   | in  | tuser: req_type; tdata: pattern_slot, element_pos, sample_value
//  m_axis   | out | tdata: window_full, end_position, matches_here, total_matches
//  cfg      | in  | cfg_we / cfg_wdata: slot_count
//
//  A load beat is a read-modify-write of one pattern row (LD_RD, then LD_WR).
//  A text beat goes straight to DONE until the window is full, or when limit,
//  slot_count clamped to NUM_PATTERNS, is 0; else it scans the first limit rows:
//  the pattern RAM delivers one row per cycle to the row of cells.
//  Reset clears the window, counters, total and output valid; patterns are not
//  cleared. A stalled result holds in the output register; the next beat is
//  taken while it waits, and only the following result waits on it.
// ============================================================================
module order_preserving_multi_matcher_top import opmm_pkg::*; #(
  parameter int PAT_LEN      = 8,
  parameter int NUM_PATTERNS = 256,
  parameter int VALUE_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] pattern_slot, [10:8] element_pos, [26:11] sample_value, [31:27] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] window_full, [32:1] end_position, [41:33] matches_here,
  // [73:42] total_matches, [79:74] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int ADDR_W = $clog2(NUM_PATTERNS > 1 ? NUM_PATTERNS : 2);
  localparam int CNT_W  = $clog2(NUM_PATTERNS + 1);
  localparam int FILL_W = $clog2(PAT_LEN + 1);
  localparam int ROW_W  = PAT_LEN * VALUE_BITS;

  typedef logic [PAT_LEN-1:0][VALUE_BITS-1:0] row_t;

  state_t state, state_next;

  logic [CFG_W-1:0]      slot_count;
  logic [7:0]            slot_q;
  logic [2:0]            el_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [FILL_W-1:0]     fill;
  logic                  full;
  logic [POS_W-1:0]      text_pos;
  logic [POS_W-1:0]      pos_q;
  logic [TOTAL_W-1:0]    total;
  logic [CNT_W-1:0]      cnt;
  logic                  rvalid;
  logic [HERE_W-1:0]     here;

  logic                  m_full;
  logic [POS_W-1:0]      m_pos;
  logic [HERE_W-1:0]     m_here;
  logic [TOTAL_W-1:0]    m_total;

  logic                  in_beat, load_ok, text_beat;
  logic [7:0]            in_slot;
  logic [2:0]            in_el;
  logic [VALUE_BITS-1:0] in_val;
  logic [FILL_W-1:0]     fill_next;
  logic [CNT_W-1:0]      limit;
  logic                  issue, out_free, iso;
  logic [TOTAL_W:0]      total_sum;
  logic [TOTAL_W-1:0]    total_next;

  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  row_t                  ram_rdata, row_mod, win;
  logic [ROW_W-1:0]      ram_rdata_flat;
  logic [PAT_LEN-1:0]    cell_ok;

  // Input beat decode
  assign s_axis_tready = (state == ST_IDLE);
  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign in_slot   = s_axis_tdata[IN_SLOT_LSB +: 8];
  assign in_el     = s_axis_tdata[IN_EL_LSB +: 3];
  assign in_val    = VALUE_BITS'(s_axis_tdata[IN_VAL_LSB +: 16]);
  assign text_beat = in_beat && (s_axis_tuser[0] == REQ_TEXT);
  assign load_ok   = in_beat && (s_axis_tuser[0] == REQ_LOAD) &&
                     (32'(in_slot) < NUM_PATTERNS) && (32'(in_el) < PAT_LEN);
  assign fill_next = (32'(fill) < PAT_LEN) ? fill + FILL_W'(1) : fill;

  // Participating patterns, clamped to the store
  assign limit = (32'(slot_count) > NUM_PATTERNS) ? CNT_W'(NUM_PATTERNS)
                                                  : CNT_W'(slot_count);
  assign issue    = (state == ST_SCAN) && (cnt < limit);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Saturating total
  assign total_sum  = {1'b0, total} + (TOTAL_W + 1)'(here);
  assign total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

  // Pattern row store
  assign ram_rdata = ram_rdata_flat;
  assign ram_we    = (state == ST_LD_WR);
  assign ram_waddr = ADDR_W'(slot_q);
  assign ram_re    = (state == ST_LD_RD) || issue;
  assign ram_raddr = (state == ST_LD_RD) ? ADDR_W'(slot_q) : ADDR_W'(cnt);

  always_comb begin
    for (int k = 0; k < PAT_LEN; k++) begin
      row_mod[k] = (32'(el_q) == k) ? val_q : ram_rdata[k];
    end
  end

  opmm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_PATTERNS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (row_mod),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata_flat)
  );

  // Row of window cells
  for (genvar i = 0; i < PAT_LEN; i++) begin : g_cell
    logic [VALUE_BITS-1:0] shift_in;
    if (i == PAT_LEN - 1) begin : g_top
      assign shift_in = in_val;
    end else begin : g_mid
      assign shift_in = win[i+1];
    end
    opmm_cell #(
      .IDX        (i),
      .PAT_LEN    (PAT_LEN),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (text_beat),
      .shift_in (shift_in),
      .win      (win),
      .pat      (ram_rdata),
      .value    (win[i]),
      .ok       (cell_ok[i])
    );
  end

  assign iso = &cell_ok;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (load_ok) begin
          state_next = ST_LD_RD;
        end else if (text_beat) begin
          state_next = ((32'(fill_next) >= PAT_LEN) && (limit != '0)) ? ST_SCAN
                                                                      : ST_DONE;
        end
      end
      ST_LD_RD: state_next = ST_LD_WR;
      ST_LD_WR: state_next = ST_IDLE;
      ST_SCAN: begin
        if (!issue && rvalid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= CFG_W'(1);
    end else if (cfg_we) begin
      slot_count <= cfg_wdata;
    end
  end

  // Capture input beat payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      slot_q <= in_slot;
      el_q   <= in_el;
      val_q  <= in_val;
    end
  end

  // Text position, fill and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      full     <= 1'b0;
      text_pos <= '0;
      total    <= '0;
      cnt      <= '0;
      rvalid   <= 1'b0;
      here     <= '0;
    end else begin
      rvalid <= issue;
      if (text_beat) begin
        fill     <= fill_next;
        full     <= (32'(fill_next) >= PAT_LEN);
        text_pos <= text_pos + POS_W'(1);
        cnt      <= '0;
        here     <= '0;
      end
      if (issue) begin
        cnt <= cnt + CNT_W'(1);
      end
      if ((state == ST_SCAN) && rvalid && iso) begin
        here <= here + HERE_W'(1);
      end
      if ((state == ST_DONE) && out_free) begin
        total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_beat) begin
      pos_q <= text_pos;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      m_full  <= full;
      m_pos   <= pos_q;
      m_here  <= here;
      m_total <= total_next;
    end
  end

  assign m_axis_tdata = {(OUT_DATA_W - OUT_PAD_LSB)'(0), m_total, m_here, m_pos, m_full};

endmodule

@@ hdl/opmm_checker.sv @@
// ============================================================================
// Matcher port checker
// Watches the matcher's stream ports and flags sequencing slips.
// ============================================================================
module opmm_checker import opmm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // One item at a time: an accepted beat drops ready
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while busy");

  // No matches before the window fills
  a_no_early_match: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[OUT_FULL_BIT]) |->
      (m_axis_tdata[OUT_HERE_LSB +: HERE_W] == '0))
    else $error("match reported before window full");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind order_preserving_multi_matcher_top opmm_checker u_opmm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// Order-preserving matcher testbench
// Loads patterns and streams text values through the matcher with random
// gaps and stalls; a scoreboard predicts each result and compares all fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import opmm_pkg::*;

  localparam int PLEN  = 8;
  localparam int NPAT  = 256;
  localparam int QG    = 3;
  localparam int NFILL = 64;
  localparam int LIMIT = 1000000;

  typedef struct packed {
    logic        full;
    logic [31:0] pos;
    logic [8:0]  here;
    logic [31:0] total;
  } match_res_t;

  int fail_count = 0;

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    fail_count++;
  endtask

  // Predictor of match results, with its own copy of block state
  class match_scoreboard;
    logic [15:0] win[PLEN];
    logic [15:0] pat[NPAT][PLEN];
    logic [2:0]  pat_print[NPAT];
    logic [31:0] next_pos;
    logic [31:0] sum;
    int          fill;
    int          active;
    match_res_t  pending[$];

    function new();
      foreach (win[i]) win[i] = '0;
      foreach (pat[i, j]) pat[i][j] = '0;
      foreach (pat_print[i]) pat_print[i] = '0;
      next_pos = '0;
      sum = '0;
      fill = 0;
      active = 1;
    endfunction

    function automatic logic [2:0] rank_print(logic [15:0] a, logic [15:0] b,
                                              logic [15:0] c);
      int fp;
      fp = (a <= b) ? 1 : 0;
      fp += 2 * (((a <= c) ? 1 : 0) + ((b <= c) ? 1 : 0));
      return fp[2:0];
    endfunction

    function automatic int rel(logic [15:0] a, logic [15:0] b);
      return (a < b) ? -1 : ((a > b) ? 1 : 0);
    endfunction

    function automatic bit iso(int s);
      for (int i = 0; i < PLEN; i++)
        for (int j = i + 1; j < PLEN; j++)
          if (rel(pat[s][i], pat[s][j]) != rel(win[i], win[j])) return 0;
      return 1;
    endfunction

    function void set_count(logic [8:0] v);
      active = (int'(v) > NPAT) ? NPAT : int'(v);
    endfunction

    // Note an accepted input beat
    function void note_input(logic kind, logic [7:0] slot, logic [2:0] el,
                             logic [15:0] val);
      match_res_t r;
      logic [2:0] fp;
      int here;
      logic [32:0] acc;
      if (kind == REQ_LOAD) begin
        pat[slot][el] = val;
        pat_print[slot] = rank_print(pat[slot][PLEN-QG], pat[slot][PLEN-2],
                                     pat[slot][PLEN-1]);
        return;
      end
      for (int i = 0; i < PLEN - 1; i++) win[i] = win[i+1];
      win[PLEN-1] = val;
      if (fill < PLEN) fill++;
      here = 0;
      if (fill >= PLEN) begin
        fp = rank_print(win[PLEN-QG], win[PLEN-2], win[PLEN-1]);
        for (int s = 0; s < active; s++)
          if (pat_print[s] == fp && iso(s)) here++;
        acc = {1'b0, sum} + 33'(here);
        sum = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
      end
      r.full = (fill >= PLEN);
      r.pos = next_pos;
      r.here = here[8:0];
      r.total = sum;
      next_pos++;
      pending.push_back(r);
    endfunction

    // Check an accepted result beat
    task check_result(input logic [OUT_DATA_W-1:0] d);
      match_res_t e;
      if (pending.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (d[OUT_FULL_BIT] !== e.full)
        report($sformatf("pos %0d window_full %0b exp %0b", e.pos,
                         d[OUT_FULL_BIT], e.full));
      if (d[OUT_POS_LSB +: 32] !== e.pos)
        report($sformatf("end_position %0d exp %0d", d[OUT_POS_LSB +: 32], e.pos));
      if (d[OUT_HERE_LSB +: 9] !== e.here)
        report($sformatf("pos %0d matches_here %0d exp %0d", e.pos,
                         d[OUT_HERE_LSB +: 9], e.here));
      if (d[OUT_TOTAL_LSB +: 32] !== e.total)
        report($sformatf("pos %0d total_matches %0d exp %0d", e.pos,
                         d[OUT_TOTAL_LSB +: 32], e.total));
    endtask
  endclass

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  cfg_we = 0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  match_scoreboard sb = new();
  bit              stall_off = 0;
  int              cycles = 0;

  order_preserving_multi_matcher_top i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Accept result beats with random back-pressure
  initial begin
    int g;
    @(posedge clk iff !rst);
    forever begin
      g = stall_off ? 0 : gap_len();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      sb.check_result(m_axis_tdata);
    end
  end

  // Send one beat, with an optional idle gap in front
  task automatic send(input logic kind, input logic [7:0] slot,
                      input logic [2:0] el, input logic [15:0] val,
                      input bit idle);
    int g;
    g = idle ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {5'b0, val, el, slot};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(kind, slot, el, val);
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (NPAT + 20) @(posedge clk);
  endtask

  task automatic set_count(input logic [8:0] v);
    go_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_count(v);
  endtask

  // Load a full pattern from the given values
  task automatic load_pattern(input int slot, input logic [15:0] v[PLEN],
                              input bit idle);
    for (int e = 0; e < PLEN; e++) send(REQ_LOAD, slot[7:0], e[2:0], v[e], idle);
  endtask

  function automatic logic [15:0] rnd_val(int mode);
    case (mode)
      0: return 16'($urandom_range(0, 3));
      1: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] v[PLEN];
    int n, slot, mode, loaded;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes in pattern 0, text matching pattern 255 outside the count
    v = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF,
          16'h0002};
    load_pattern(0, v, 0);
    for (int e = 0; e < PLEN; e++) v[e] = 16'(e);
    load_pattern(255, v, 0);
    for (int i = 0; i < PLEN; i++) send(REQ_TEXT, 8'hFF, 3'h7, 16'(i * 100), 0);
    send(REQ_TEXT, 8'h00, 3'h0, 16'hFFFF, 0);
    send(REQ_TEXT, 8'hAA, 3'h5, 16'h0000, 0);

    // Fill the low slots so every count used below reads written rows
    for (int s = 1; s < NFILL; s++) begin
      mode = $urandom_range(0, 2);
      for (int e = 0; e < PLEN; e++) v[e] = rnd_val(mode);
      load_pattern(s, v, 0);
    end
    set_count(9'(NFILL));
    for (int i = 0; i < 10; i++) send(REQ_TEXT, 0, 0, 16'(i), 1);
    set_count(9'(NFILL / 2));
    for (int i = 0; i < 10; i++) send(REQ_TEXT, 0, 0, 16'(20 - i), 1);
    set_count(9'd0);
    for (int i = 0; i < 5; i++) send(REQ_TEXT, 0, 0, 16'hFFFF, 1);

    // Random phases with different pattern counts
    loaded = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_count(9'd1);
        1: set_count(9'd16);
        2: set_count(9'($urandom_range(2, NFILL)));
        3: set_count(9'd4);
        4: set_count(9'(NFILL));
        default: set_count(9'($urandom_range(1, NFILL)));
      endcase
      if (ph == 3) stall_off = 1;
      if (ph == 4) stall_off = 0;
      n = 0;
      while (n < 45) begin
        mode = $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) begin
          // Reload a pattern in the active range, sometimes as a text copy
          slot = $urandom_range(0, (sb.active > 0) ? sb.active - 1 : 0);
          for (int e = 0; e < PLEN; e++) v[e] = rnd_val(mode);
          load_pattern(slot, v, 1);
          n += PLEN;
          if ($urandom_range(0, 1)) begin
            for (int e = 0; e < PLEN; e++)
              send(REQ_TEXT, 8'($urandom), 3'($urandom), v[e], 1);
            n += PLEN;
          end
        end else begin
          send(REQ_TEXT, 8'($urandom), 3'($urandom), rnd_val(mode), 1);
          n++;
        end
      end
      if (ph == 2) begin
        // Hold the sender until every result is back
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (NPAT + 20) @(posedge clk);
    if (fail_count == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
